@@ sv/spwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-phase SPWM package
// Shared constants, configuration and command types, and the quarter-wave
// sine table built at elaboration.
// ----------------------------------------------------------------------------
package spwm_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int QTR_BITS        = TABLE_ADDR_BITS - 2;
    localparam int QTR             = 1 << QTR_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CMP_W      = 16;
    localparam int SINE_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd3;

    localparam logic [15:0] M_ONE       = 16'd32768;
    localparam logic [15:0] PERIOD_RST  = 16'd65535;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [PHASE_BITS-1:0] PH_THIRD =
        PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);

    typedef enum logic [1:0] {
        LANE_U,
        LANE_V,
        LANE_W
    } lane_t;

    typedef struct packed {
        logic                  enable;
        logic [PHASE_BITS-1:0] phase_step;
        logic [15:0]           mod_index;
        logic [15:0]           period;
    } cfg_t;

    typedef struct packed {
        logic  clear_phase;
        logic  sine_en;
        logic  mul_en;
        logic  scale_en;
        logic  store_en;
        logic  load_out;
        lane_t lane;
    } ctrl_cmd_t;

    typedef logic [SINE_W-2:0] sine_qtr_t [QTR];

    function automatic logic [SINE_W-2:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        d  = ((x2 * t) >> 30) / 64'd110;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd72;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd42;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd20;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd6;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_W-2:0];
    endfunction

    function automatic sine_qtr_t build_sine_qtr();
        sine_qtr_t tab;
        for (int k = 0; k < QTR; k++) begin
            tab[k] = quarter_sine((64'(k) * HALF_PI_Q30) >> QTR_BITS);
        end
        return tab;
    endfunction

    localparam sine_qtr_t SINE_QTR = build_sine_qtr();
    localparam logic [SINE_W-2:0] SINE_PEAK =
        quarter_sine((64'(QTR) * HALF_PI_Q30) >> QTR_BITS);

endpackage

@@ sv/spwm_regs.sv @@
// ----------------------------------------------------------------------------
// SPWM configuration registers
// Write port decode for enable, phase step, modulation index and period.
// ----------------------------------------------------------------------------
module spwm_regs
    import spwm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t        cfg_reg;
    logic [15:0] mod_in;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign mod_in    = cfg_data[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.phase_step <= '0;
            cfg_reg.mod_index  <= '0;
            cfg_reg.period     <= PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ENABLE:     cfg_reg.enable     <= cfg_data[0];
                CFG_PHASE_STEP: cfg_reg.phase_step <= PHASE_BITS'(cfg_data);
                CFG_MOD_INDEX:  cfg_reg.mod_index  <= (mod_in > M_ONE) ? M_ONE : mod_in;
                CFG_PERIOD:     cfg_reg.period     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

@@ sv/spwm_dpath.sv @@
// ----------------------------------------------------------------------------
// SPWM datapath
// Phase accumulator, sine lookup, modulation and period scaling, lane
// result registers and the output item register.
// ----------------------------------------------------------------------------
module spwm_dpath
    import spwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  ctrl_cmd_t         cmd,
    output logic [3*CMP_W-1:0] out_data
);

    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      ph_sel;
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [1:0]                 quad;
    logic [QTR_BITS-1:0]        r;
    logic [QTR_BITS:0]          k;
    logic [SINE_W-2:0]          mag;
    logic signed [SINE_W-1:0]   sine_next;
    logic signed [SINE_W-1:0]   sine_reg;
    logic signed [32:0]         prod_next;
    logic signed [32:0]         prod_reg;
    logic signed [32:0]         lvl_sum;
    logic [30:0]                level;
    logic [46:0]                scaled;
    logic [CMP_W-1:0]           cnt_reg;
    logic [CMP_W-1:0]           clamped;
    logic [CMP_W-1:0]           cmp_u_reg;
    logic [CMP_W-1:0]           cmp_v_reg;
    logic [CMP_W-1:0]           cmp_w_reg;
    logic [3*CMP_W-1:0]         out_data_reg;

    always_comb begin
        unique case (cmd.lane)
            LANE_U:  ph_sel = phase_reg;
            LANE_V:  ph_sel = phase_reg - PH_THIRD;
            LANE_W:  ph_sel = phase_reg + PH_THIRD;
            default: ph_sel = phase_reg;
        endcase
    end

    assign addr      = ph_sel[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign quad      = addr[TABLE_ADDR_BITS-1 -: 2];
    assign r         = addr[QTR_BITS-1:0];
    assign k         = quad[0] ? ((QTR_BITS+1)'(QTR) - {1'b0, r}) : {1'b0, r};
    assign mag       = k[QTR_BITS] ? SINE_PEAK : SINE_QTR[k[QTR_BITS-1:0]];
    assign sine_next = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    assign prod_next = 33'($signed({1'b0, cfg.mod_index})) * 33'(sine_reg);
    assign lvl_sum   = prod_reg + (33'sd1 <<< 30);
    assign level     = lvl_sum[30:0];
    assign scaled    = 47'(cfg.period) * 47'(level);
    assign clamped   = (cnt_reg > cfg.period) ? cfg.period : cnt_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cmd.clear_phase) begin
            phase_reg <= '0;
        end else if (cmd.load_out) begin
            phase_reg <= phase_reg + cfg.phase_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sine_en) begin
            sine_reg <= sine_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.scale_en) begin
            cnt_reg <= scaled[46:31];
        end
        if (cmd.store_en) begin
            unique case (cmd.lane)
                LANE_U:  cmp_u_reg <= clamped;
                LANE_V:  cmp_v_reg <= clamped;
                LANE_W:  cmp_w_reg <= clamped;
                default: ;
            endcase
        end
        if (cmd.load_out) begin
            out_data_reg <= {cmp_w_reg, cmp_v_reg, cmp_u_reg};
        end
    end

endmodule

@@ sv/spwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// SPWM controller
// Sequences one tick through the three lanes and hands the item to the
// output register.
// ----------------------------------------------------------------------------
module spwm_ctrl
    import spwm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      restart,
    input  logic      enable,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINE,
        S_MUL,
        S_SCALE,
        S_STORE,
        S_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    lane_t  lane_reg;
    lane_t  lane_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd             = '0;
        cmd.lane        = lane_reg;
        state_next      = state_reg;
        lane_next       = lane_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                cmd.clear_phase = accept && restart;
                if (accept && enable) begin
                    state_next = S_SINE;
                    lane_next  = LANE_U;
                end
            end
            S_SINE: begin
                cmd.sine_en = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale_en = 1'b1;
                state_next   = S_STORE;
            end
            S_STORE: begin
                cmd.store_en = 1'b1;
                unique case (lane_reg)
                    LANE_U: begin
                        lane_next  = LANE_V;
                        state_next = S_SINE;
                    end
                    LANE_V: begin
                        lane_next  = LANE_W;
                        state_next = S_SINE;
                    end
                    default: begin
                        state_next = S_WAIT;
                    end
                endcase
            end
            S_WAIT: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            lane_reg      <= LANE_U;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/three_phase_spwm_generator_core.sv @@
// ----------------------------------------------------------------------------
// Three-phase SPWM generator core
// Each accepted enabled tick is stepped through sine, multiply, scale and store
// for each lane, then the output item is loaded, m_tvalid is raised and the
// controller returns to idle; a disabled tick finishes in its accept cycle. A new
// tick is taken only in idle, and a held item stalls the load.
// Reset (aresetn low, synchronous): phase zero, registers at reset values.
// ----------------------------------------------------------------------------
module three_phase_spwm_generator_core
    import spwm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [0] restart
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [3*CMP_W-1:0]     m_tdata,    // [15:0] compare_u, [31:16] compare_v,
                                               // [47:32] compare_w
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;

    spwm_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .enable   (cfg.enable),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spwm_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .out_data (m_tdata)
    );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for three_phase_spwm_generator_core
// Sends PWM ticks over the input stream and writes the four control registers
// between phases while the core is idle. A local model of the phase
// accumulator and the quarter-wave sine lookup predicts the three compare
// counts of every enabled tick. Each item on the output stream is checked in
// order against that prediction. The tests cover the reset defaults, disabled
// ticks and restart, quadrant boundaries, the modulation and period extremes,
// and random phases with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spwm_pkg::*;

    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = 24;
    localparam logic [31:0] TURN_THIRD  = 32'd1431655765;
    localparam int unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] w;
    } duty_set_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;      // [0] restart
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [3*CMP_W-1:0]    m_tdata;             // [15:0] u, [31:16] v, [47:32] w
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // duty model state
    logic        duty_enable;
    logic [31:0] duty_step;
    logic [15:0] duty_mod;
    logic [15:0] duty_period;
    logic [31:0] duty_phase;
    int          sine_lut [1024];

    duty_set_t   pending_duty [$];
    duty_set_t   head_duty;
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          rx_stall = 0;

    three_phase_spwm_generator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int sine_q15(input logic [9:0] addr);
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] s;
        k  = addr[8] ? (64'd256 - 64'(addr[7:0])) : 64'(addr[7:0]);
        x  = (k * 64'd1686629713) >> 8;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int i = 0; i < 5; i++) begin
            d = ((x2 * t) >> 30) / 64'(TAYLOR_DIV[i]);
            t = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
        end
        s = (((x * t) >> 30) + (64'd1 << 14)) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return addr[9] ? -int'(s) : int'(s);
    endfunction

    function automatic logic [15:0] compare_count(input logic [31:0] phase);
        longint level;
        longint cnt;
        level = (longint'(1) << 30) + longint'(duty_mod) * longint'(sine_lut[phase[31:22]]);
        cnt   = (longint'(duty_period) * level) >>> 31;
        if (cnt > longint'(duty_period)) begin
            cnt = longint'(duty_period);
        end
        return cnt[15:0];
    endfunction

    function automatic void predict_tick(input logic restart);
        duty_set_t ds;
        if (restart) begin
            duty_phase = '0;
        end
        if (!duty_enable) begin
            return;
        end
        ds.u = compare_count(duty_phase);
        ds.v = compare_count(duty_phase - TURN_THIRD);
        ds.w = compare_count(duty_phase + TURN_THIRD);
        pending_duty.push_back(ds);
        duty_phase = duty_phase + duty_step;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [31:0] value);
        case (idx)
            CFG_ENABLE: begin
                duty_enable = value[0];
            end
            CFG_PHASE_STEP: begin
                duty_step = value;
            end
            CFG_MOD_INDEX: begin
                duty_mod = (value[15:0] > M_ONE) ? M_ONE : value[15:0];
            end
            CFG_PERIOD: begin
                duty_period = value[15:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end else if (r < 98) begin
            return $urandom_range(5, 16);
        end else begin
            return $urandom_range(20, 40);
        end
    endfunction

    always @(posedge aclk) begin
        if (rx_steady) begin
            m_tready <= 1'b1;
            rx_stall = 0;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                rx_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_duty.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                error_count++;
            end else begin
                head_duty = pending_duty.pop_front();
                if (m_tdata[15:0] !== head_duty.u) begin
                    $display("%0t: compare_u expected %0d actual %0d",
                             $realtime, head_duty.u, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[31:16] !== head_duty.v) begin
                    $display("%0t: compare_v expected %0d actual %0d",
                             $realtime, head_duty.v, m_tdata[31:16]);
                    error_count++;
                end
                if (m_tdata[47:32] !== head_duty.w) begin
                    $display("%0t: compare_w expected %0d actual %0d",
                             $realtime, head_duty.w, m_tdata[47:32]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("** three_phase_spwm_generator_core: FAILED **");
            $finish;
        end
    end

    task automatic send_tick(input logic restart);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        predict_tick(restart);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop the input stream and wait out every pending result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_duty.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_disabled_ticks();
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();
    endtask

    task automatic test_reset_defaults();
        write_reg(CFG_PHASE_STEP, 32'd0);
        write_reg(CFG_ENABLE, 32'd1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();
    endtask

    task automatic test_quadrants();
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        write_reg(CFG_MOD_INDEX, 32'd32768);
        write_reg(CFG_PERIOD, 32'd65535);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        drain();
    endtask

    task automatic test_mod_saturation();
        write_reg(CFG_PHASE_STEP, 32'h2000_0000);
        write_reg(CFG_MOD_INDEX, 32'hFFFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();
        write_reg(CFG_MOD_INDEX, 32'd32769);
        send_tick(1'b0);
        drain();
    endtask

    task automatic test_period_extremes();
        write_reg(CFG_PERIOD, 32'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        drain();
        write_reg(CFG_PERIOD, 32'd1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain();
        write_reg(CFG_MOD_INDEX, 32'd0);
        write_reg(CFG_PERIOD, 32'd65535);
        send_tick(1'b0);
        drain();
    endtask

    task automatic test_restart_while_disabled();
        write_reg(CFG_MOD_INDEX, 32'd32768);
        write_reg(CFG_PHASE_STEP, 32'h1234_5678);
        send_tick(1'b0);
        send_tick(1'b0);
        drain();
        write_reg(CFG_ENABLE, 32'd0);
        send_tick(1'b0);
        drain();
        write_reg(CFG_ENABLE, 32'd1);
        send_tick(1'b0);
        drain();
        write_reg(CFG_ENABLE, 32'd0);
        send_tick(1'b1);
        drain();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        send_tick(1'b0);
        send_tick(1'b0);
        drain();
        write_reg(CFG_PHASE_STEP, 32'd1);
        send_tick(1'b0);
        drain();
    endtask

    task automatic test_random_phases();
        logic [31:0] step;
        logic [31:0] modv;
        logic [31:0] per;
        logic        en;
        int          n_items;
        for (int p = 0; p < 13; p++) begin
            case ($urandom_range(0, 3))
                0: step = $urandom();
                1: step = $urandom_range(0, 1 << 20);
                2: step = $urandom() | 32'h8000_0000;
                default: step = {10'($urandom_range(0, 1023)), 22'd0};
            endcase
            if (p == 0) begin
                modv = 32'd32768;
                per  = 32'd65535;
            end else if (p == 1) begin
                modv = 32'd0;
                per  = 32'd0;
            end else if (p == 2) begin
                modv = 32'hFFFF_FFFF;
                per  = 32'd1;
            end else begin
                modv = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32768);
                per  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 65535);
            end
            en        = (p != 5);
            tx_steady = (p % 4 == 3);
            rx_steady = (p % 4 == 3);
            write_reg(CFG_PHASE_STEP, step);
            write_reg(CFG_MOD_INDEX, modv);
            write_reg(CFG_PERIOD, per);
            write_reg(CFG_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), en});
            n_items = en ? 144 : 20;
            for (int i = 0; i < n_items; i++) begin
                send_tick($urandom_range(0, 19) == 0);
            end
            drain();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        for (int a = 0; a < 1024; a++) begin
            sine_lut[a] = sine_q15(a[9:0]);
        end
        duty_enable = 1'b0;
        duty_step   = '0;
        duty_mod    = '0;
        duty_period = PERIOD_RST;
        duty_phase  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled_ticks();
        test_reset_defaults();
        test_quadrants();
        test_mod_saturation();
        test_period_extremes();
        test_restart_while_disabled();
        test_random_phases();

        if (error_count == 0) begin
            $display("** three_phase_spwm_generator_core: PASSED **");
        end else begin
            $display("** three_phase_spwm_generator_core: FAILED **");
        end
        $finish;
    end

endmodule
